>>> rtl/core/u8dec_pkg.sv
// u8dec_pkg: shared types, constants and helpers for the UTF-8 code point decoder.
// No dependencies; used by u8dec_core and utf8_codepoint_decoder_top.
package u8dec_pkg;

   localparam int CP_WIDTH  = 21;
   localparam int LEN_WIDTH = 3;

   // claimed length codes; LEN_IDLE means no sequence pending
   localparam logic [LEN_WIDTH-1:0] LEN_IDLE = 3'd0;
   localparam logic [LEN_WIDTH-1:0] LEN_ONE  = 3'd1;
   localparam logic [LEN_WIDTH-1:0] LEN_TWO  = 3'd2;
   localparam logic [LEN_WIDTH-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_WIDTH-1:0] LEN_FOUR = 3'd4;

   localparam logic [7:0] TERMINATOR = 8'h00;

   typedef struct packed {
      logic                 truncated;
      logic                 is_combining;
      logic [LEN_WIDTH-1:0] seq_length;
      logic [CP_WIDTH-1:0]  code_point;
   } result_type;

   function automatic logic in_combining(input logic [CP_WIDTH-1:0] cp);
      logic hit;
      hit = (cp inside {[21'h000300:21'h00036F]}) ||
            (cp inside {[21'h001AB0:21'h001AFF]}) ||
            (cp inside {[21'h001DC0:21'h001DFF]}) ||
            (cp inside {[21'h0020D0:21'h0020FF]}) ||
            (cp inside {[21'h00FE20:21'h00FE2F]});
      return hit;
   endfunction

endpackage

>>> rtl/core/u8dec_core.sv
// u8dec_core: sequence state and single-pass decode of one accepted byte.
// Depends on u8dec_pkg. Produces at most one result per beat.
module u8dec_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   beat_valid,
   input  logic [7:0]             beat_byte,
   output logic                   res_valid,
   output u8dec_pkg::result_type  res_data
);
   import u8dec_pkg::*;

   logic [7:0]           lead_ff, lead_in;
   logic [LEN_WIDTH-1:0] claimed_ff, claimed_in;
   logic [LEN_WIDTH-1:0] seen_ff, seen_in;
   logic [CP_WIDTH-1:0]  partial_ff, partial_in;

   logic [LEN_WIDTH-1:0] seen_inc;
   logic [CP_WIDTH-1:0]  partial_shift;
   logic [CP_WIDTH-1:0]  cp_sel;

   assign seen_inc      = seen_ff + LEN_ONE;
   assign partial_shift = {partial_ff[CP_WIDTH-7:0], beat_byte[5:0]};

   always_comb begin
      lead_in    = lead_ff;
      claimed_in = claimed_ff;
      seen_in    = seen_ff;
      partial_in = partial_ff;
      res_valid  = 1'b0;
      cp_sel     = {{(CP_WIDTH-8){1'b0}}, beat_byte};
      res_data.seq_length = LEN_ONE;
      res_data.truncated  = 1'b0;

      if (beat_valid) begin
         if (claimed_ff == LEN_IDLE) begin
            if (beat_byte == TERMINATOR) begin
               res_valid = 1'b0;
            end else if (beat_byte inside {[8'hC0:8'hDF]}) begin
               lead_in    = beat_byte;
               claimed_in = LEN_TWO;
               seen_in    = LEN_ONE;
               partial_in = {{(CP_WIDTH-5){1'b0}}, beat_byte[4:0]};
            end else if (beat_byte inside {[8'hE0:8'hEF]}) begin
               lead_in    = beat_byte;
               claimed_in = LEN_THREE;
               seen_in    = LEN_ONE;
               partial_in = {{(CP_WIDTH-4){1'b0}}, beat_byte[3:0]};
            end else if (beat_byte inside {[8'hF0:8'hF7]}) begin
               lead_in    = beat_byte;
               claimed_in = LEN_FOUR;
               seen_in    = LEN_ONE;
               partial_in = {{(CP_WIDTH-3){1'b0}}, beat_byte[2:0]};
            end else begin
               // ASCII or invalid lead: pass the byte through as is
               res_valid = 1'b1;
            end
         end else if (beat_byte == TERMINATOR) begin
            res_valid           = 1'b1;
            cp_sel              = {{(CP_WIDTH-8){1'b0}}, lead_ff};
            res_data.seq_length = seen_ff;
            res_data.truncated  = 1'b1;
            lead_in    = '0;
            claimed_in = LEN_IDLE;
            seen_in    = '0;
            partial_in = '0;
         end else if (seen_inc >= claimed_ff) begin
            res_valid           = 1'b1;
            cp_sel              = partial_shift;
            res_data.seq_length = claimed_ff;
            lead_in    = '0;
            claimed_in = LEN_IDLE;
            seen_in    = '0;
            partial_in = '0;
         end else begin
            // continuation byte, top two bits ignored
            seen_in    = seen_inc;
            partial_in = partial_shift;
         end
      end

      res_data.code_point   = cp_sel;
      res_data.is_combining = in_combining(cp_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff    <= '0;
         claimed_ff <= LEN_IDLE;
         seen_ff    <= '0;
         partial_ff <= '0;
      end else begin
         lead_ff    <= lead_in;
         claimed_ff <= claimed_in;
         seen_ff    <= seen_in;
         partial_ff <= partial_in;
      end
   end

endmodule

>>> rtl/core/utf8_codepoint_decoder_top.sv
// utf8_codepoint_decoder_top: byte-serial UTF-8 decoder with registered result and skid.
// Depends on u8dec_pkg and u8dec_core.
// A result is registered in the output entry, or in skid while the output entry stalls.
// Throughput: one byte per cycle; the two-entry result buffer (output + skid)
// keeps req_tready high unless the skid entry is occupied.
// Reset: synchronous, active high; clears sequence state and empties the buffer.
module utf8_codepoint_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] seq_length
   output logic [1:0]  rsp_tuser    // [0] is_combining, [1] truncated
);
   import u8dec_pkg::*;

   logic       beat;
   logic       res_valid;
   result_type res_data;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign req_tready = !skid_valid_ff;
   assign beat       = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;

   u8dec_core u_core (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat),
      .beat_byte  (req_tdata),
      .res_valid  (res_valid),
      .res_data   (res_data)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (beat && res_valid) begin
         if (!out_valid_ff || pop) begin
            out_in       = res_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.seq_length, out_ff.code_point};
   assign rsp_tuser  = {out_ff.truncated, out_ff.is_combining};

   // skid entry only fills behind a stalled output entry
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid while output entry empty");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.seq_length != LEN_IDLE) && (out_ff.seq_length <= LEN_FOUR))
      else $error("result length out of range");

   // truncated results carry the lead byte, never a combining code point
   a_trunc_shape: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.truncated) |->
         (out_ff.code_point[CP_WIDTH-1:8] == '0) && !out_ff.is_combining &&
         (out_ff.seq_length < LEN_FOUR))
      else $error("malformed truncated result");

   a_single_is_byte: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.truncated && out_ff.seq_length == LEN_ONE) |->
         (out_ff.code_point[CP_WIDTH-1:8] == '0) && (out_ff.code_point[7:0] != TERMINATOR))
      else $error("single-byte result not a plain byte");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (beat && res_valid) |=> out_valid_ff)
      else $error("produced result not buffered");

endmodule

>>> verif/utf8_codepoint_decoder_checker.sv
// utf8_codepoint_decoder_checker: watches both streams of the UTF-8 decoder, predicts each
// decoded character from the accepted text bytes and compares field by field.
// Depends on u8dec_pkg for the result layout and length codes.
module utf8_codepoint_decoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] seq_length
   input  logic [1:0]  rsp_tuser,   // [0] is_combining, [1] truncated
   output int          fail_count,
   output int          pending_chars,
   output int          chars_checked,
   output int          truncated_seen,
   output int          combining_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import u8dec_pkg::*;

   // decoder state as the predictor sees it
   logic [7:0]           lead_byte;
   logic [LEN_WIDTH-1:0] claim_len;
   logic [LEN_WIDTH-1:0] seen_count;
   logic [CP_WIDTH-1:0]  partial_cp;

   result_type expected_chars[$];
   int errors;
   int n_chars;
   int n_trunc;
   int n_comb;

   assign fail_count     = errors;
   assign chars_checked  = n_chars;
   assign truncated_seen = n_trunc;
   assign combining_seen = n_comb;

   initial begin
      errors  = 0;
      n_chars = 0;
      n_trunc = 0;
      n_comb  = 0;
   end

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
   endtask

   function automatic logic combining_range(input logic [CP_WIDTH-1:0] cp);
      return (cp >= 21'h0300 && cp <= 21'h036F) || (cp >= 21'h1AB0 && cp <= 21'h1AFF) ||
             (cp >= 21'h1DC0 && cp <= 21'h1DFF) || (cp >= 21'h20D0 && cp <= 21'h20FF) ||
             (cp >= 21'hFE20 && cp <= 21'hFE2F);
   endfunction

   task automatic push_char(input logic [CP_WIDTH-1:0] cp, input logic [LEN_WIDTH-1:0] len,
                            input logic trunc);
      result_type r;
      r.code_point   = cp;
      r.seq_length   = len;
      r.is_combining = combining_range(cp);
      r.truncated    = trunc;
      expected_chars.push_back(r);
   endtask

   task automatic clear_sequence();
      lead_byte  = '0;
      claim_len  = LEN_IDLE;
      seen_count = '0;
      partial_cp = '0;
   endtask

   task automatic decode_byte(input logic [7:0] b);
      if (claim_len == LEN_IDLE) begin
         if (b != TERMINATOR) begin
            if (b[7:5] == 3'b110) begin
               claim_len  = LEN_TWO;
               partial_cp = CP_WIDTH'(b[4:0]);
            end else if (b[7:4] == 4'b1110) begin
               claim_len  = LEN_THREE;
               partial_cp = CP_WIDTH'(b[3:0]);
            end else if (b[7:3] == 5'b11110) begin
               claim_len  = LEN_FOUR;
               partial_cp = CP_WIDTH'(b[2:0]);
            end else begin
               // plain ASCII and stray/invalid leads go out as one-byte chars
               push_char(CP_WIDTH'(b), LEN_ONE, 1'b0);
            end
            if (claim_len != LEN_IDLE) begin
               lead_byte  = b;
               seen_count = LEN_ONE;
            end
         end
      end else if (b == TERMINATOR) begin
         push_char(CP_WIDTH'(lead_byte), seen_count, 1'b1);
         clear_sequence();
      end else begin
         // top two bits are not checked: any nonzero byte continues the sequence
         partial_cp = {partial_cp[CP_WIDTH-7:0], b[5:0]};
         seen_count = seen_count + LEN_ONE;
         if (seen_count >= claim_len) begin
            push_char(partial_cp, claim_len, 1'b0);
            clear_sequence();
         end
      end
   endtask

   task automatic check_char();
      result_type want;
      result_type got;
      got.code_point   = rsp_tdata[20:0];
      got.seq_length   = rsp_tdata[23:21];
      got.is_combining = rsp_tuser[0];
      got.truncated    = rsp_tuser[1];
      if (expected_chars.size() == 0) begin
         report_error($sformatf("unexpected char cp=%h len=%0d", got.code_point,
                                got.seq_length));
      end else begin
         want = expected_chars.pop_front();
         n_chars++;
         if (want.truncated) n_trunc++;
         if (want.is_combining) n_comb++;
         if (got.code_point !== want.code_point)
            report_error($sformatf("code_point %h, want %h", got.code_point, want.code_point));
         if (got.seq_length !== want.seq_length)
            report_error($sformatf("seq_length %0d, want %0d (cp %h)", got.seq_length,
                                   want.seq_length, want.code_point));
         if (got.is_combining !== want.is_combining)
            report_error($sformatf("is_combining %b, want %b (cp %h)", got.is_combining,
                                   want.is_combining, want.code_point));
         if (got.truncated !== want.truncated)
            report_error($sformatf("truncated %b, want %b (cp %h)", got.truncated,
                                   want.truncated, want.code_point));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_sequence();
         expected_chars.delete();
      end else begin
         // a result beat was produced by an earlier byte, so check before predicting
         if (rsp_tvalid && rsp_tready) check_char();
         if (req_tvalid && req_tready) decode_byte(req_tdata);
      end
      pending_chars <= expected_chars.size();
   end

endmodule

>>> verif/utf8_codepoint_decoder_top_tb.sv
// utf8_codepoint_decoder_top_tb: drives text bytes into the UTF-8 decoder with bursty
// valid and a stalling receiver; checking is done by utf8_codepoint_decoder_checker.
// Depends on u8dec_pkg, utf8_codepoint_decoder_top and the checker.
module utf8_codepoint_decoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import u8dec_pkg::*;

   localparam int RANDOM_BYTES = 800;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DIRECTED_LEN = 23;
   localparam logic [7:0] DIRECTED_TEXT [DIRECTED_LEN] = '{
      8'h00,                       // terminator with nothing pending
      8'h01, 8'h7F,                // ASCII extremes
      8'h80, 8'hFF,                // invalid leads
      8'hCC, 8'h80,                // U+0300, combining
      8'hEF, 8'hB8, 8'hAF,         // U+FE2F, top of the last combining range
      8'hF7, 8'hFF, 8'hFF, 8'hFF,  // largest value a 4-byte lead can carry
      8'hC3, 8'h41,                // non-continuation byte taken as continuation
      8'hE2, 8'h00,                // cut after the lead
      8'hF0, 8'h90, 8'h80, 8'h00,  // cut after three bytes
      8'h00                        // terminator right after a terminator
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int fail_count;
   int pending_chars;
   int chars_checked;
   int truncated_seen;
   int combining_seen;

   int bytes_sent = 0;
   int burst_left = 0;
   int cycle_count = 0;
   int stall_mode = 0;
   int stall_phase = 0;

   utf8_codepoint_decoder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   utf8_codepoint_decoder_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .fail_count     (fail_count),
      .pending_chars  (pending_chars),
      .chars_checked  (chars_checked),
      .truncated_seen (truncated_seen),
      .combining_seen (combining_seen)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d chars still expected", cycle_count,
                  pending_chars);
         $display("utf8_codepoint_decoder_top_tb: done, errors");
         $finish;
      end
   end

   // receiver: a new stall pattern is drawn each time stall_phase wraps
   always @(negedge clock) begin
      if (stall_phase == 0) stall_mode <= $urandom_range(0, 3);
      stall_phase <= (stall_phase + 1) % 64;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_phase % 8) < 5;
      endcase
   end

   // one beat on the byte stream; valid only drops between bursts
   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 48);
      end
      req_tdata  <= b;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (pending_chars != 0);
   endtask

   // lead of the given length followed by n_cont bytes, proper or arbitrary nonzero
   task automatic send_sequence(input int len, input int n_cont, input bit noisy);
      logic [7:0] r;
      r = 8'($urandom);
      case (len)
         2: send_byte({3'b110, r[4:0]});
         3: send_byte({4'b1110, r[3:0]});
         default: send_byte({5'b11110, r[2:0]});
      endcase
      for (int i = 0; i < n_cont; i++) begin
         r = 8'($urandom);
         if (noisy) send_byte(8'($urandom_range(1, 255)));
         else send_byte({2'b10, r[5:0]});
      end
   endtask

   task automatic send_scalar(input logic [20:0] cp);
      if (cp < 21'h80) begin
         send_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
         send_byte({3'b110, cp[10:6]});
         send_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         send_byte({4'b1110, cp[15:12]});
         send_byte({2'b10, cp[11:6]});
         send_byte({2'b10, cp[5:0]});
      end else begin
         send_byte({5'b11110, cp[20:18]});
         send_byte({2'b10, cp[17:12]});
         send_byte({2'b10, cp[11:6]});
         send_byte({2'b10, cp[5:0]});
      end
   endtask

   // scalar at, just outside, or inside one of the combining ranges
   task automatic send_combining_probe();
      logic [20:0] lo;
      logic [20:0] hi;
      case ($urandom_range(0, 4))
         0: begin lo = 21'h0300; hi = 21'h036F; end
         1: begin lo = 21'h1AB0; hi = 21'h1AFF; end
         2: begin lo = 21'h1DC0; hi = 21'h1DFF; end
         3: begin lo = 21'h20D0; hi = 21'h20FF; end
         default: begin lo = 21'hFE20; hi = 21'hFE2F; end
      endcase
      case ($urandom_range(0, 4))
         0: send_scalar(lo - 21'd1);
         1: send_scalar(lo);
         2: send_scalar(hi);
         3: send_scalar(hi + 21'd1);
         default: send_scalar(21'($urandom_range(lo, hi)));
      endcase
   endtask

   initial begin
      int pick;
      int len;
      bit drained;
      drained = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_TEXT[i]) send_byte(DIRECTED_TEXT[i]);

      while (bytes_sent < DIRECTED_LEN + RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         len  = $urandom_range(2, 4);
         if (pick < 20) send_byte(8'($urandom_range(1, 127)));
         else if (pick < 68) send_sequence(len, len - 1, 1'b0);
         else if (pick < 75) send_combining_probe();
         else if (pick < 80) begin
            if ($urandom_range(0, 1)) send_byte(8'($urandom_range(8'h80, 8'hBF)));
            else send_byte(8'($urandom_range(8'hF8, 8'hFF)));
         end else if (pick < 88) begin
            send_sequence(len, $urandom_range(0, len - 2), 1'b0);
            send_byte(TERMINATOR);
         end else if (pick < 96) send_sequence(len, len - 1, 1'b1);
         else send_byte(TERMINATOR);

         if (!drained && bytes_sent >= DIRECTED_LEN + RANDOM_BYTES / 2) begin
            wait_for_results();
            drained = 1'b1;
         end
      end
      send_byte(TERMINATOR);   // flush any open sequence
      wait_for_results();
      repeat (4) @(posedge clock);

      $display("sent %0d text bytes; %0d characters compared", bytes_sent, chars_checked);
      $display("%0d cut short by a terminator, %0d in combining ranges", truncated_seen,
               combining_seen);
      if (fail_count == 0) begin
         $display("utf8_codepoint_decoder_top_tb: done, clean");
      end else begin
         $display("utf8_codepoint_decoder_top_tb: done, errors");
      end
      $finish;
   end

endmodule
